>>> hw/rtl/edff_pkg.sv
// shared types, constants, microcode program and helpers of the echo delay unit
`timescale 1ns / 1ps
`default_nettype none

package edff_pkg;

  // field and datapath widths
  localparam int SAMPLE_W = 16;
  localparam int IN_W     = 19;
  localparam int TAP_W    = 8;
  localparam int NUM_TAPS = 8;
  localparam int HIST_AW  = 3;
  localparam int GAIN_W   = 10;
  localparam int LEN_W    = 14;
  localparam int ACC_W    = 27;
  localparam int MUL_A_W  = 19;
  localparam int PROD_W   = 29;
  localparam int SUM_W    = 22;
  localparam int CFG_W    = 64;
  localparam int CFG_AW   = 2;
  localparam int STEP_W   = 3;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_DELAY_LENGTH  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_FEEDBACK_GAIN = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_ECHO_VOLUME   = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_FIR_TAPS      = 2'd3;

  // configuration reset values
  localparam logic [LEN_W-1:0]         RST_DELAY_LENGTH  = 14'd4180;
  localparam logic signed [GAIN_W-1:0] RST_FEEDBACK_GAIN = 10'sd150;
  localparam logic signed [GAIN_W-1:0] RST_ECHO_VOLUME   = 10'sd96;
  localparam logic [CFG_W-1:0]         RST_FIR_TAPS      = 64'h0E12161A1E222830;

  // shared multiplier operand select
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_TAP,
    MUL_FB,
    MUL_VOL
  } mul_sel_t;

  // conditional jump kinds
  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_TAP_LOOP,
    JMP_OUT_WAIT
  } jmp_t;

  typedef logic [STEP_W-1:0] step_t;

  // program steps
  localparam step_t STEP_READ = 3'd0;
  localparam step_t STEP_HIST = 3'd1;
  localparam step_t STEP_MAC  = 3'd2;
  localparam step_t STEP_ACC  = 3'd3;
  localparam step_t STEP_FB   = 3'd4;
  localparam step_t STEP_WR   = 3'd5;
  localparam step_t STEP_OUT  = 3'd6;

  // one control word
  typedef struct packed {
    logic     hist_wr;
    logic     acc_clr;
    logic     acc_add;
    mul_sel_t mul_sel;
    logic     mem_wr;
    logic     out_ld;
    jmp_t     jmp;
    step_t    target;
    logic     last;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic tap_last;
    logic out_full;
  } stat_t;

  // microcode rom
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    w = '0;
    case (s)
      STEP_READ: begin
      end
      STEP_HIST: begin
        w.hist_wr = 1'b1;
        w.acc_clr = 1'b1;
      end
      STEP_MAC: begin
        w.mul_sel = MUL_TAP;
        w.acc_add = 1'b1;
        w.jmp     = JMP_TAP_LOOP;
        w.target  = STEP_MAC;
      end
      STEP_ACC: begin
        w.acc_add = 1'b1;
      end
      STEP_FB: begin
        w.mul_sel = MUL_FB;
      end
      STEP_WR: begin
        w.mem_wr  = 1'b1;
        w.mul_sel = MUL_VOL;
      end
      STEP_OUT: begin
        w.out_ld = 1'b1;
        w.jmp    = JMP_OUT_WAIT;
        w.target = STEP_OUT;
        w.last   = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

  // saturate to signed 16 bits
  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > 22'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -22'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/edff_seq.sv
// microcode sequencer: step counter, control rom and conditional jumps
`timescale 1ns / 1ps
`default_nettype none

module edff_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start_i,
  input  wire edff_pkg::stat_t stat_i,
  output logic                 busy_o,
  output edff_pkg::ctrl_t      ctrl_o
);

  logic              busy_r, busy_nxt;
  edff_pkg::step_t   step_r, step_nxt;
  edff_pkg::ctrl_t   word;
  logic              take;

  assign word = edff_pkg::ucode(step_r);

  // jump condition
  always_comb begin
    case (word.jmp)
      edff_pkg::JMP_TAP_LOOP: take = !stat_i.tap_last;
      edff_pkg::JMP_OUT_WAIT: take = stat_i.out_full;
      default:                take = 1'b0;
    endcase
  end

  // gated control word
  always_comb begin
    ctrl_o = '0;
    if (busy_r) begin
      ctrl_o = word;
      if (take) begin
        ctrl_o.out_ld = 1'b0;
      end
    end
  end

  // next step
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (!busy_r) begin
      if (start_i) begin
        busy_nxt = 1'b1;
        step_nxt = edff_pkg::STEP_READ;
      end
    end else if (take) begin
      step_nxt = word.target;
    end else if (word.last) begin
      busy_nxt = 1'b0;
    end else begin
      step_nxt = edff_pkg::step_t'(step_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= edff_pkg::STEP_READ;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  assign busy_o = busy_r;

endmodule

`default_nettype wire

>>> hw/rtl/edff_datapath.sv
// datapath: settings, delay memory, history, shared multiplier, accumulator, output register
`timescale 1ns / 1ps
`default_nettype none

module edff_datapath #(
  parameter int DELAY_DEPTH = 8192
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    cfg_we_i,
  input  wire logic [edff_pkg::CFG_AW-1:0]             cfg_addr_i,
  input  wire logic [edff_pkg::CFG_W-1:0]              cfg_wdata_i,
  input  wire logic                                    in_load_i,
  input  wire logic signed [edff_pkg::IN_W-1:0]        dry_i,
  input  wire logic signed [edff_pkg::IN_W-1:0]        send_i,
  input  wire edff_pkg::ctrl_t                         ctrl_i,
  input  wire logic                                    out_tready_i,
  output edff_pkg::stat_t                              stat_o,
  output logic                                         out_valid_o,
  output logic signed [edff_pkg::SAMPLE_W-1:0]         out_data_o
);

  localparam int PW = $clog2(DELAY_DEPTH);
  localparam int FW = $clog2(DELAY_DEPTH + 1);
  localparam int CW = ((FW > edff_pkg::LEN_W) ? FW : edff_pkg::LEN_W) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DELAY_DEPTH);

  // settings
  logic [edff_pkg::LEN_W-1:0]         dlen_r;
  logic signed [edff_pkg::GAIN_W-1:0] fb_r;
  logic signed [edff_pkg::GAIN_W-1:0] vol_r;
  logic [edff_pkg::CFG_W-1:0]         taps_r;

  // item state
  logic signed [edff_pkg::IN_W-1:0]     dry_r, send_r;
  logic [PW-1:0]                        pos_r;
  logic [FW-1:0]                        fill_r;
  logic [edff_pkg::HIST_AW-1:0]         hp_r;
  logic [edff_pkg::HIST_AW-1:0]         tap_cnt_r;
  logic signed [edff_pkg::SAMPLE_W-1:0] hist_r [edff_pkg::NUM_TAPS];
  logic signed [edff_pkg::SAMPLE_W-1:0] rd_r;
  logic signed [edff_pkg::SAMPLE_W-1:0] mem [DELAY_DEPTH];
  logic signed [edff_pkg::ACC_W-1:0]    acc_r;
  logic signed [edff_pkg::PROD_W-1:0]   prod_r;
  logic                                 out_valid_r;
  logic signed [edff_pkg::SAMPLE_W-1:0] out_data_r;

  logic signed [edff_pkg::MUL_A_W-1:0]  mul_a;
  logic signed [edff_pkg::GAIN_W-1:0]   mul_b;
  logic signed [edff_pkg::PROD_W-1:0]   prod;
  logic signed [edff_pkg::SAMPLE_W-1:0] hist_rd;
  logic signed [edff_pkg::TAP_W-1:0]    tap;
  logic [edff_pkg::HIST_AW-1:0]         hist_idx;
  logic signed [edff_pkg::SUM_W-1:0]    scaled;
  logic signed [edff_pkg::SAMPLE_W-1:0] wr_val, mix_val;
  logic                                 rd_valid;
  logic [CW-1:0]                        len_ext, eff_len, pos_inc;
  logic [PW-1:0]                        pos_next;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dlen_r <= edff_pkg::RST_DELAY_LENGTH;
      fb_r   <= edff_pkg::RST_FEEDBACK_GAIN;
      vol_r  <= edff_pkg::RST_ECHO_VOLUME;
      taps_r <= edff_pkg::RST_FIR_TAPS;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        edff_pkg::CFG_DELAY_LENGTH:  dlen_r <= cfg_wdata_i[edff_pkg::LEN_W-1:0];
        edff_pkg::CFG_FEEDBACK_GAIN: fb_r   <= cfg_wdata_i[edff_pkg::GAIN_W-1:0];
        edff_pkg::CFG_ECHO_VOLUME:   vol_r  <= cfg_wdata_i[edff_pkg::GAIN_W-1:0];
        edff_pkg::CFG_FIR_TAPS:      taps_r <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (in_load_i) begin
      dry_r  <= dry_i;
      send_r <= send_i;
    end
  end

  // delay memory, read data registered
  always_ff @(posedge clk) begin
    if (ctrl_i.mem_wr) begin
      mem[pos_r] <= wr_val;
    end
    rd_r <= mem[pos_r];
  end

  // entries past the fill mark were never written and read as zero
  assign rd_valid = (FW'(pos_r) < fill_r);

  // history tap select and coefficient select
  assign hist_idx = hp_r - tap_cnt_r;
  assign hist_rd  = hist_r[hist_idx];
  assign tap      = taps_r[{tap_cnt_r, 3'b000} +: edff_pkg::TAP_W];

  // shared multiplier operands
  always_comb begin
    case (ctrl_i.mul_sel)
      edff_pkg::MUL_TAP: begin
        mul_a = edff_pkg::MUL_A_W'(hist_rd);
        mul_b = edff_pkg::GAIN_W'(tap);
      end
      edff_pkg::MUL_FB: begin
        mul_a = acc_r[edff_pkg::ACC_W-1:8];
        mul_b = fb_r;
      end
      edff_pkg::MUL_VOL: begin
        mul_a = acc_r[edff_pkg::ACC_W-1:8];
        mul_b = vol_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // scaled echo plus send or dry, saturated
  assign scaled  = edff_pkg::SUM_W'($signed(prod_r[edff_pkg::PROD_W-1:8]));
  assign wr_val  = edff_pkg::sat16(edff_pkg::SUM_W'(send_r) + scaled);
  assign mix_val = edff_pkg::sat16(edff_pkg::SUM_W'(dry_r) + scaled);

  // position wrap at the effective length
  always_comb begin
    len_ext = CW'(dlen_r);
    if (len_ext == '0) begin
      eff_len = CW'(1);
    end else if (len_ext > DEPTH_C) begin
      eff_len = DEPTH_C;
    end else begin
      eff_len = len_ext;
    end
    pos_inc  = CW'(pos_r) + CW'(1);
    pos_next = (pos_inc >= eff_len) ? '0 : pos_inc[PW-1:0];
  end

  // multiplier product and accumulator
  always_ff @(posedge clk) begin
    if (ctrl_i.acc_clr) begin
      prod_r <= '0;
      acc_r  <= '0;
    end else begin
      if (ctrl_i.mul_sel != edff_pkg::MUL_NONE) begin
        prod_r <= prod;
      end
      if (ctrl_i.acc_add) begin
        acc_r <= acc_r + prod_r[edff_pkg::ACC_W-1:0];
      end
    end
  end

  // control state, history and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      fill_r      <= '0;
      hp_r        <= '0;
      tap_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < edff_pkg::NUM_TAPS; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      if (ctrl_i.hist_wr) begin
        hist_r[hp_r] <= rd_valid ? rd_r : '0;
      end
      if (ctrl_i.acc_clr) begin
        tap_cnt_r <= '0;
      end else if (ctrl_i.mul_sel == edff_pkg::MUL_TAP) begin
        tap_cnt_r <= tap_cnt_r + 1'b1;
      end
      if (ctrl_i.mem_wr && (FW'(pos_r) == fill_r)) begin
        fill_r <= fill_r + 1'b1;
      end
      if (ctrl_i.out_ld) begin
        out_valid_r <= 1'b1;
        pos_r       <= pos_next;
        hp_r        <= hp_r + 1'b1;
      end else if (out_tready_i) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.out_ld) begin
      out_data_r <= mix_val;
    end
  end

  assign stat_o.tap_last = (tap_cnt_r == edff_pkg::HIST_AW'(edff_pkg::NUM_TAPS - 1));
  assign stat_o.out_full = out_valid_r && !out_tready_i;
  assign out_valid_o     = out_valid_r;
  assign out_data_o      = out_data_r;

endmodule

`default_nettype wire

>>> hw/rtl/echo_delay_fir_feedback_top.sv
// Echo delay unit with an 8-tap FIR in the feedback path.
// Input channel (in_*): one request carries a dry mix sample and an echo-send
// sample. Output channel (out_*): one mixed sample per input request, in order.
// Configuration (cfg_*): delay length, feedback gain, echo volume and packed FIR
// taps; write only while no request is in flight.
// Each request runs a short microcode program on one shared multiplier: read
// the delay memory, push into the tap history, eight multiply-accumulate passes,
// feedback scale and write-back, volume scale and output load.
// Requests are worked one at a time; the pace is set by the eight passes through the
// single multiplier plus the read, scale and write steps around them.
// in_tready is high only while no request is being worked on; the output
// register lets the next request start while a result still waits.
// If the receiver stalls with a result already held, the program waits on its
// output step and the held result is not overwritten.
// Reset (synchronous, rst_n low) restores the register defaults, clears the
// history and the position, and marks the whole delay memory as empty through
// a fill mark, so no clearing pass is needed and requests are taken at once.
`timescale 1ns / 1ps
`default_nettype none

module echo_delay_fir_feedback_top #(
  parameter int DELAY_DEPTH = 8192
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [edff_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [edff_pkg::CFG_W-1:0]    cfg_wdata,
  // input stream
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [39:0]                   in_tdata,   // dry_sample[18:0], send_sample[37:19]
  // output stream
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [15:0]                        out_tdata   // mixed_sample[15:0]
);

  logic            busy;
  logic            in_accept;
  edff_pkg::ctrl_t ctrl;
  edff_pkg::stat_t stat;
  logic signed [edff_pkg::SAMPLE_W-1:0] mixed;

  assign in_tready = !busy;
  assign in_accept = in_tvalid && in_tready;

  // program sequencer
  edff_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (in_accept),
    .stat_i  (stat),
    .busy_o  (busy),
    .ctrl_o  (ctrl)
  );

  // datapath
  edff_datapath #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata),
    .in_load_i    (in_accept),
    .dry_i        (in_tdata[18:0]),
    .send_i       (in_tdata[37:19]),
    .ctrl_i       (ctrl),
    .out_tready_i (out_tready),
    .stat_o       (stat),
    .out_valid_o  (out_tvalid),
    .out_data_o   (mixed)
  );

  assign out_tdata = mixed;

endmodule

`default_nettype wire
